// ===== rtl/srr_pkg.sv =====
// Shared types and constants of the sound reactive retract controller.
// Depends on nothing; every other file of the block imports it.
package srr_pkg;

   localparam int TIME_BITS  = 32;
   localparam int POS_BITS   = 12;
   localparam int LEVEL_BITS = 16;
   localparam int MODE_BITS  = 3;
   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = 16;

   // Mode codes.
   localparam logic [MODE_BITS-1:0] MODE_IN        = 3'd0;
   localparam logic [MODE_BITS-1:0] MODE_HALF      = 3'd1;
   localparam logic [MODE_BITS-1:0] MODE_OUT       = 3'd2;
   localparam logic [MODE_BITS-1:0] MODE_MOVE_OUT  = 3'd3;
   localparam logic [MODE_BITS-1:0] MODE_MOVE_HALF = 3'd4;
   localparam logic [MODE_BITS-1:0] MODE_MOVE_IN   = 3'd5;

   // Configuration register indexes.
   localparam logic [CSR_IDX_BITS-1:0] CSR_LOUD_THR   = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MEDIUM_THR = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_FREEZE_TO  = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MOVE_TO    = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_IN_POS     = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] CSR_HALF_POS   = 3'd5;
   localparam logic [CSR_IDX_BITS-1:0] CSR_OUT_POS    = 3'd6;
   localparam logic [CSR_IDX_BITS-1:0] CSR_POS_TOL    = 3'd7;

   // Reset values of the configuration registers.
   localparam logic [LEVEL_BITS-1:0] RST_LOUD_THR   = 16'd49152;
   localparam logic [LEVEL_BITS-1:0] RST_MEDIUM_THR = 16'd24576;
   localparam logic [15:0]           RST_FREEZE_TO  = 16'd5000;
   localparam logic [15:0]           RST_MOVE_TO    = 16'd1000;
   localparam logic [POS_BITS-1:0]   RST_IN_POS     = 12'd0;
   localparam logic [POS_BITS-1:0]   RST_HALF_POS   = 12'd2048;
   localparam logic [POS_BITS-1:0]   RST_OUT_POS    = 12'd4095;
   localparam logic [POS_BITS-1:0]   RST_POS_TOL    = 12'd16;

   typedef struct packed {
      logic [LEVEL_BITS-1:0] loud_threshold;
      logic [LEVEL_BITS-1:0] medium_threshold;
      logic [15:0]           freeze_timeout;
      logic [15:0]           move_timeout;
      logic [POS_BITS-1:0]   in_position;
      logic [POS_BITS-1:0]   half_position;
      logic [POS_BITS-1:0]   out_position;
      logic [POS_BITS-1:0]   position_tolerance;
   } cfg_type;

   typedef struct packed {
      logic [TIME_BITS-1:0]  now_ms;
      logic [LEVEL_BITS-1:0] loudness;
      logic [POS_BITS-1:0]   position;
   } item_type;

   typedef struct packed {
      logic [MODE_BITS-1:0] mode;
      logic [POS_BITS-1:0]  target_position;
      logic                 speed_is_fast;
      logic                 idle;
   } result_type;

endpackage

// ===== rtl/srr_if.sv =====
// Valid/ready channel interfaces for the request and response sides.
// Depends on srr_pkg for the field widths.
interface srr_req_if import srr_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [TIME_BITS-1:0]  now_ms;
   logic [LEVEL_BITS-1:0] loudness;
   logic [POS_BITS-1:0]   position;

   modport source (output valid, output now_ms, output loudness, output position,
                   input ready);
   modport sink (input valid, input now_ms, input loudness, input position,
                 output ready);
endinterface

interface srr_rsp_if import srr_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [MODE_BITS-1:0] mode;
   logic [POS_BITS-1:0]  target_position;
   logic                 speed_is_fast;
   logic                 idle;

   modport source (output valid, output mode, output target_position,
                   output speed_is_fast, output idle, input ready);
   modport sink (input valid, input mode, input target_position,
                 input speed_is_fast, input idle, output ready);
endinterface

// ===== rtl/sound_reactive_retract_fsm.sv =====
// Sound reactive retract controller, top level.
// A request is registered in the input register and its result in the result register.
// Throughput: one item per cycle while results are taken; the mode checks are combinational between
// the input register and the result register, so items follow back to back.
// Reset (synchronous): configuration returns to defaults, the mode to moving in
// with fast speed toward the in pose, and both pipeline stages empty.
module sound_reactive_retract_fsm import srr_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   srr_req_if.sink                  req_chan,
   srr_rsp_if.source                rsp_chan,
   input  logic                     csr_we,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata
);

   cfg_type    cfg;
   item_type   item_ff;
   logic       in_vld_ff, in_vld_in;
   result_type result;
   result_type out_ff;
   logic       out_vld_ff, out_vld_in;
   logic       advance;
   logic       req_take;

   // The user must hold the configuration registers steady while items are in
   // flight; the block does not enforce it. The mode checks read them directly.
   srr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // The item in the input register moves on when the result register is
   // empty or its contents are transferred out in the same cycle. The mode
   // state updates on that same edge, so the following item sees it.
   assign advance  = in_vld_ff && (!out_vld_ff || rsp_chan.ready);
   assign req_chan.ready = !in_vld_ff || advance;
   assign req_take = req_chan.valid && req_chan.ready;

   srr_core u_core (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .item    (item_ff),
      .cfg     (cfg),
      .result  (result)
   );

   always_comb begin
      in_vld_in = in_vld_ff;
      if (req_take) begin
         in_vld_in = 1'b1;
      end else if (advance) begin
         in_vld_in = 1'b0;
      end
      out_vld_in = out_vld_ff;
      if (advance) begin
         out_vld_in = 1'b1;
      end else if (rsp_chan.ready) begin
         out_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   // Payload registers carry no reset; their valid flags qualify them.
   always_ff @(posedge clock) begin
      if (req_take) begin
         item_ff.now_ms   <= req_chan.now_ms;
         item_ff.loudness <= req_chan.loudness;
         item_ff.position <= req_chan.position;
      end
      if (advance) begin
         out_ff <= result;
      end
   end

   assign rsp_chan.valid           = out_vld_ff;
   assign rsp_chan.mode            = out_ff.mode;
   assign rsp_chan.target_position = out_ff.target_position;
   assign rsp_chan.speed_is_fast   = out_ff.speed_is_fast;
   assign rsp_chan.idle            = out_ff.idle;

endmodule

// ===== rtl/srr_csr.sv =====
// Configuration register file of the retract controller.
// Depends on srr_pkg for the register layout, indexes and reset values.
module srr_csr import srr_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_we,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata,
   output cfg_type                  cfg
);

   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.loud_threshold     <= RST_LOUD_THR;
         cfg_ff.medium_threshold   <= RST_MEDIUM_THR;
         cfg_ff.freeze_timeout     <= RST_FREEZE_TO;
         cfg_ff.move_timeout       <= RST_MOVE_TO;
         cfg_ff.in_position        <= RST_IN_POS;
         cfg_ff.half_position      <= RST_HALF_POS;
         cfg_ff.out_position       <= RST_OUT_POS;
         cfg_ff.position_tolerance <= RST_POS_TOL;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_LOUD_THR:   cfg_ff.loud_threshold     <= csr_wdata;
            CSR_MEDIUM_THR: cfg_ff.medium_threshold   <= csr_wdata;
            CSR_FREEZE_TO:  cfg_ff.freeze_timeout     <= csr_wdata;
            CSR_MOVE_TO:    cfg_ff.move_timeout       <= csr_wdata;
            CSR_IN_POS:     cfg_ff.in_position        <= csr_wdata[POS_BITS-1:0];
            CSR_HALF_POS:   cfg_ff.half_position      <= csr_wdata[POS_BITS-1:0];
            CSR_OUT_POS:    cfg_ff.out_position       <= csr_wdata[POS_BITS-1:0];
            CSR_POS_TOL:    cfg_ff.position_tolerance <= csr_wdata[POS_BITS-1:0];
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/srr_core.sv =====
// Mode state registers and the chained mode checks of the retract controller.
// Depends on srr_pkg for the mode codes and the item, result and config types.
module srr_core import srr_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       step_en,
   input  item_type   item,
   input  cfg_type    cfg,
   output result_type result
);

   logic [MODE_BITS-1:0] mode_ff, mode_in;
   logic [POS_BITS-1:0]  target_ff, target_in;
   logic                 fast_ff, fast_in;
   logic                 idle_ff, idle_in;
   logic [TIME_BITS-1:0] wait_ff, wait_in;
   logic [TIME_BITS-1:0] move_ff, move_in;

   function automatic logic elapsed_over(input logic [TIME_BITS-1:0] now,
                                         input logic [TIME_BITS-1:0] start,
                                         input logic [15:0] limit);
      logic [TIME_BITS-1:0] diff;
      diff = now - start;
      return diff > TIME_BITS'(limit);
   endfunction

   function automatic logic near_target(input logic [POS_BITS-1:0] pos,
                                        input logic [POS_BITS-1:0] tgt,
                                        input logic [POS_BITS-1:0] tol);
      logic [POS_BITS-1:0] gap;
      gap = (pos > tgt) ? pos - tgt : tgt - pos;
      return gap < tol;
   endfunction

   // The checks run in a fixed order and each sees the changes made by the
   // ones before it, so the next state is built up through blocking updates.
   always_comb begin
      logic loud_hi;
      logic med_hi;
      logic med_lo;
      mode_in   = mode_ff;
      target_in = target_ff;
      fast_in   = fast_ff;
      idle_in   = idle_ff;
      wait_in   = wait_ff;
      move_in   = move_ff;
      loud_hi   = item.loudness > cfg.loud_threshold;
      med_hi    = item.loudness > cfg.medium_threshold;
      med_lo    = item.loudness < cfg.medium_threshold;

      if (mode_in == MODE_IN) begin
         if (med_hi) begin
            wait_in = item.now_ms;
            idle_in = 1'b1;
         end
         if (elapsed_over(item.now_ms, wait_in, cfg.freeze_timeout)) begin
            mode_in   = MODE_MOVE_OUT;
            fast_in   = 1'b0;
            target_in = cfg.out_position;
            idle_in   = 1'b0;
            wait_in   = item.now_ms;
         end
      end

      if (mode_in == MODE_HALF) begin
         if (loud_hi) begin
            mode_in   = MODE_MOVE_IN;
            fast_in   = 1'b1;
            target_in = cfg.in_position;
            idle_in   = 1'b0;
            move_in   = item.now_ms;
         end else if (med_lo && elapsed_over(item.now_ms, wait_in, cfg.freeze_timeout)) begin
            mode_in   = MODE_MOVE_OUT;
            fast_in   = 1'b0;
            target_in = cfg.out_position;
            idle_in   = 1'b0;
         end
      end

      if (mode_in == MODE_OUT) begin
         if (loud_hi) begin
            mode_in   = MODE_MOVE_IN;
            fast_in   = 1'b1;
            target_in = cfg.in_position;
            idle_in   = 1'b0;
            move_in   = item.now_ms;
         end else if (med_hi) begin
            mode_in   = MODE_MOVE_HALF;
            fast_in   = 1'b1;
            target_in = cfg.half_position;
            idle_in   = 1'b0;
            move_in   = item.now_ms;
         end
      end

      if (mode_in == MODE_MOVE_OUT) begin
         if (loud_hi) begin
            mode_in   = MODE_MOVE_IN;
            fast_in   = 1'b1;
            target_in = cfg.in_position;
            idle_in   = 1'b0;
            move_in   = item.now_ms;
         end else if (med_hi && item.position > cfg.half_position) begin
            mode_in   = MODE_MOVE_HALF;
            fast_in   = 1'b1;
            target_in = cfg.half_position;
            idle_in   = 1'b0;
            move_in   = item.now_ms;
         end else if (near_target(item.position, target_in, cfg.position_tolerance)) begin
            mode_in = MODE_OUT;
            idle_in = 1'b1;
         end
      end

      if (mode_in == MODE_MOVE_HALF) begin
         if (loud_hi) begin
            // The move start time carries over from the half move.
            mode_in   = MODE_MOVE_IN;
            fast_in   = 1'b1;
            target_in = cfg.in_position;
            idle_in   = 1'b0;
         end else if (near_target(item.position, target_in, cfg.position_tolerance) &&
                      elapsed_over(item.now_ms, move_in, cfg.move_timeout)) begin
            mode_in = MODE_HALF;
            wait_in = item.now_ms;
            idle_in = 1'b1;
         end
      end

      if (mode_in == MODE_MOVE_IN) begin
         if (near_target(item.position, target_in, cfg.position_tolerance) &&
             elapsed_over(item.now_ms, move_in, cfg.move_timeout)) begin
            mode_in = MODE_IN;
            wait_in = item.now_ms;
            idle_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_MOVE_IN;
         target_ff <= RST_IN_POS;
         fast_ff   <= 1'b1;
         idle_ff   <= 1'b0;
         wait_ff   <= '0;
         move_ff   <= '0;
      end else if (step_en) begin
         mode_ff   <= mode_in;
         target_ff <= target_in;
         fast_ff   <= fast_in;
         idle_ff   <= idle_in;
         wait_ff   <= wait_in;
         move_ff   <= move_in;
      end
   end

   assign result.mode            = mode_in;
   assign result.target_position = target_in;
   assign result.speed_is_fast   = fast_in;
   assign result.idle            = idle_in;

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for sound_reactive_retract_fsm: directed mode walks, then random
// sensor readings under several register settings. Depends on srr_pkg and the srr_if channels.
module tb_top;
   import srr_pkg::*;

   // The run is cut off here if it hangs.
   localparam int LIMIT_CYCLES = 500000;

   logic clock;
   logic reset;
   logic                     csr_we;
   logic [CSR_IDX_BITS-1:0]  csr_index;
   logic [CSR_DATA_BITS-1:0] csr_wdata;

   srr_req_if req_bus ();
   srr_rsp_if rsp_bus ();

   sound_reactive_retract_fsm dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Predictor state. The configuration copy tracks every register write, and the
   // mode state follows the accepted readings in transfer order.
   cfg_type              cfg;
   logic [MODE_BITS-1:0] st_mode;
   logic [POS_BITS-1:0]  st_target;
   logic                 st_fast;
   logic                 st_idle;
   logic [TIME_BITS-1:0] quiet_since;
   logic [TIME_BITS-1:0] move_since;

   // Expected results, oldest first; one entry is pushed per accepted reading.
   result_type pending_results[$];

   // Running clock of the random readings, so that most time stamps move forward.
   logic [TIME_BITS-1:0] sim_ms;

   int send_idle_pct;
   int recv_idle_pct;
   int fail_count;
   int readings_sent;
   int results_checked;
   int settings_applied;
   int cycle_count;
   int mode_seen[6];

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // -------------------------------------------------------------------------
   // Predictor
   // -------------------------------------------------------------------------

   // A time span counts as expired only when strictly greater than the limit.
   // The subtraction wraps at the width of the time stamp, so the span across a
   // counter rollover is still correct.
   function automatic bit timed_out(logic [TIME_BITS-1:0] now, logic [TIME_BITS-1:0] start,
                                    logic [15:0] limit);
      logic [TIME_BITS-1:0] span;
      span = now - start;
      return span > limit;
   endfunction

   function automatic bit near_target(logic [POS_BITS-1:0] pos);
      logic [POS_BITS-1:0] gap;
      gap = (pos > st_target) ? pos - st_target : st_target - pos;
      return gap < cfg.position_tolerance;
   endfunction

   // Retract fully and fast. Coming from moving half, the move timer keeps its old
   // start; every other entry restarts it.
   function automatic void head_in(logic [TIME_BITS-1:0] now, bit restart);
      st_mode   = MODE_MOVE_IN;
      st_fast   = 1'b1;
      st_target = cfg.in_position;
      st_idle   = 1'b0;
      if (restart)
         move_since = now;
   endfunction

   function automatic void head_half(logic [TIME_BITS-1:0] now);
      st_mode    = MODE_MOVE_HALF;
      st_fast    = 1'b1;
      st_target  = cfg.half_position;
      st_idle    = 1'b0;
      move_since = now;
   endfunction

   // Moving out is the only slow move and it does not touch the move timer.
   function automatic void head_out();
      st_mode   = MODE_MOVE_OUT;
      st_fast   = 1'b0;
      st_target = cfg.out_position;
      st_idle   = 1'b0;
   endfunction

   // One step of the retract controller. The mode checks run strictly in the order
   // in, half, out, moving out, moving half, moving in, and each check sees the
   // mode left by the checks above it, so a single reading can chain several moves
   // (for example half -> moving out -> out when the member already sits outside).
   function automatic result_type retract_step(item_type rd);
      result_type res;
      if (st_mode == MODE_IN) begin
         // A medium sound while in keeps the freeze timer restarted.
         if (rd.loudness > cfg.medium_threshold) begin
            quiet_since = rd.now_ms;
            st_idle     = 1'b1;
         end
         if (timed_out(rd.now_ms, quiet_since, cfg.freeze_timeout)) begin
            head_out();
            quiet_since = rd.now_ms;
         end
      end
      if (st_mode == MODE_HALF) begin
         if (rd.loudness > cfg.loud_threshold)
            head_in(rd.now_ms, 1'b1);
         else if (rd.loudness < cfg.medium_threshold &&
                  timed_out(rd.now_ms, quiet_since, cfg.freeze_timeout))
            head_out();
      end
      if (st_mode == MODE_OUT) begin
         if (rd.loudness > cfg.loud_threshold)
            head_in(rd.now_ms, 1'b1);
         else if (rd.loudness > cfg.medium_threshold)
            head_half(rd.now_ms);
      end
      if (st_mode == MODE_MOVE_OUT) begin
         if (rd.loudness > cfg.loud_threshold) begin
            head_in(rd.now_ms, 1'b1);
         end else if (rd.loudness > cfg.medium_threshold &&
                      rd.position > cfg.half_position) begin
            head_half(rd.now_ms);
         end else if (near_target(rd.position)) begin
            st_mode = MODE_OUT;
            st_idle = 1'b1;
         end
      end
      if (st_mode == MODE_MOVE_HALF) begin
         if (rd.loudness > cfg.loud_threshold) begin
            head_in(rd.now_ms, 1'b0);
         end else if (near_target(rd.position) &&
                      timed_out(rd.now_ms, move_since, cfg.move_timeout)) begin
            st_mode     = MODE_HALF;
            quiet_since = rd.now_ms;
            st_idle     = 1'b1;
         end
      end
      if (st_mode == MODE_MOVE_IN) begin
         if (near_target(rd.position) &&
             timed_out(rd.now_ms, move_since, cfg.move_timeout)) begin
            st_mode     = MODE_IN;
            quiet_since = rd.now_ms;
            st_idle     = 1'b1;
         end
      end
      res.mode            = st_mode;
      res.target_position = st_target;
      res.speed_is_fast   = st_fast;
      res.idle            = st_idle;
      return res;
   endfunction

   // -------------------------------------------------------------------------
   // Stimulus helpers
   // -------------------------------------------------------------------------

   function automatic item_type make_item(logic [TIME_BITS-1:0] now,
                                          logic [LEVEL_BITS-1:0] level,
                                          logic [POS_BITS-1:0] pos);
      item_type rd;
      rd.now_ms   = now;
      rd.loudness = level;
      rd.position = pos;
      return rd;
   endfunction

   // Builds a plausible reading from the current predicted state. Most readings
   // advance the running clock and aim at the interesting edges: timeouts that
   // just expire or just miss, levels right at the thresholds, and positions just
   // inside or just outside the tolerance around the current target. A small share
   // is pure noise over the full range of every field.
   function automatic item_type next_reading();
      item_type    rd;
      int          pick;
      int unsigned offset;
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
         rd.now_ms   = $urandom;
         rd.loudness = LEVEL_BITS'($urandom);
         rd.position = POS_BITS'($urandom);
         sim_ms      = rd.now_ms;
         return rd;
      end

      pick = $urandom_range(0, 99);
      if (pick < 45)
         sim_ms = sim_ms + $urandom_range(0, cfg.move_timeout / 4 + 3);
      else if (pick < 65)
         sim_ms = sim_ms + $urandom_range(0, cfg.freeze_timeout / 2 + 3);
      else if (pick < 78)
         sim_ms = quiet_since + cfg.freeze_timeout + $urandom_range(0, 1);
      else if (pick < 91)
         sim_ms = move_since + cfg.move_timeout + $urandom_range(0, 1);
      else if (pick < 96)
         sim_ms = sim_ms + $urandom;
      rd.now_ms = sim_ms;

      pick = $urandom_range(0, 99);
      if (pick < 35)
         rd.loudness = (cfg.medium_threshold == 0) ? '0 :
                       LEVEL_BITS'($urandom_range(0, cfg.medium_threshold - 1));
      else if (pick < 55)
         rd.loudness = LEVEL_BITS'($urandom_range(cfg.medium_threshold, cfg.loud_threshold));
      else if (pick < 70)
         rd.loudness = LEVEL_BITS'($urandom_range(cfg.loud_threshold, 16'hFFFF));
      else if (pick < 85)
         case ($urandom_range(0, 3))
            0:       rd.loudness = cfg.medium_threshold;
            1:       rd.loudness = cfg.medium_threshold + 1'b1;
            2:       rd.loudness = cfg.loud_threshold;
            default: rd.loudness = cfg.loud_threshold + 1'b1;
         endcase
      else
         rd.loudness = LEVEL_BITS'($urandom);

      pick = $urandom_range(0, 99);
      if (pick < 50) begin
         // Offset up to and including the tolerance, which is just out of reach.
         offset = $urandom_range(0, cfg.position_tolerance);
         if ($urandom_range(0, 1))
            rd.position = POS_BITS'(st_target + offset);
         else
            rd.position = POS_BITS'(st_target - offset);
      end else if (pick < 60) begin
         rd.position = POS_BITS'(cfg.half_position + $urandom_range(0, 2) - 1);
      end else begin
         rd.position = POS_BITS'($urandom);
      end
      return rd;
   endfunction

   // Offers one reading and holds it until the transfer completes. Valid is left
   // high afterwards so that back-to-back readings need no extra assignment; the
   // next call either replaces the payload or drops valid for an idle gap.
   task automatic send_reading(input item_type rd);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.now_ms   <= rd.now_ms;
      req_bus.loudness <= rd.loudness;
      req_bus.position <= rd.position;
      do
         @(posedge clock);
      while (!req_bus.ready);
      pending_results.push_back(retract_step(rd));
      readings_sent++;
   endtask

   task automatic run_random(input int count);
      for (int k = 0; k < count; k++)
         send_reading(next_reading());
   endtask

   // Stops offering readings and waits until every expected result has come back.
   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      while (pending_results.size() != 0)
         @(posedge clock);
   endtask

   // One register write per clock edge. The predictor copy is updated once the
   // write has been taken, with the 12-bit position registers masked.
   task automatic set_reg(input logic [CSR_IDX_BITS-1:0] idx,
                          input logic [CSR_DATA_BITS-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         CSR_LOUD_THR:   cfg.loud_threshold     = data;
         CSR_MEDIUM_THR: cfg.medium_threshold   = data;
         CSR_FREEZE_TO:  cfg.freeze_timeout     = data;
         CSR_MOVE_TO:    cfg.move_timeout       = data;
         CSR_IN_POS:     cfg.in_position        = data[POS_BITS-1:0];
         CSR_HALF_POS:   cfg.half_position      = data[POS_BITS-1:0];
         CSR_OUT_POS:    cfg.out_position       = data[POS_BITS-1:0];
         CSR_POS_TOL:    cfg.position_tolerance = data[POS_BITS-1:0];
      endcase
   endtask

   // Rewrites all eight registers, only once the block has gone quiet.
   task automatic write_settings(input logic [15:0] loud_thr, input logic [15:0] medium_thr,
                                 input logic [15:0] freeze_ms, input logic [15:0] move_ms,
                                 input logic [15:0] in_pos, input logic [15:0] half_pos,
                                 input logic [15:0] out_pos, input logic [15:0] pos_tol);
      wait_drained();
      set_reg(CSR_LOUD_THR, loud_thr);
      set_reg(CSR_MEDIUM_THR, medium_thr);
      set_reg(CSR_FREEZE_TO, freeze_ms);
      set_reg(CSR_MOVE_TO, move_ms);
      set_reg(CSR_IN_POS, in_pos);
      set_reg(CSR_HALF_POS, half_pos);
      set_reg(CSR_OUT_POS, out_pos);
      set_reg(CSR_POS_TOL, pos_tol);
      csr_we <= 1'b0;
      settings_applied++;
   endtask

   // -------------------------------------------------------------------------
   // Tests
   // -------------------------------------------------------------------------

   // A hand-built walk through every mode with the reset settings. It covers the
   // settle into the in pose, a medium sound restarting the freeze timer, the
   // interrupted half move whose move timer is not restarted, the equal-threshold
   // cases, a chained half -> moving out -> out step, a time stamp rollover, and
   // the extremes of every field.
   task automatic test_directed_walk();
      send_reading(make_item(32'd500, 16'd0, 12'd0));
      send_reading(make_item(32'd1001, 16'd0, 12'd4095));
      send_reading(make_item(32'd1001, 16'd0, 12'd5));
      send_reading(make_item(32'd3000, 16'd30000, 12'd0));
      send_reading(make_item(32'd8001, 16'd0, 12'd0));
      send_reading(make_item(32'd8050, 16'd30000, 12'd2048));
      send_reading(make_item(32'd8100, 16'd30000, 12'd3000));
      send_reading(make_item(32'd8200, 16'hFFFF, 12'd2048));
      // Only the move start from the half move makes this one long enough.
      send_reading(make_item(32'd9101, 16'd0, 12'd0));
      send_reading(make_item(32'd14102, 16'd0, 12'd0));
      send_reading(make_item(32'd14200, 16'd0, 12'd4095));
      send_reading(make_item(32'd14300, 16'd30000, 12'd2048));
      send_reading(make_item(32'd15301, 16'd0, 12'd2048));
      send_reading(make_item(32'd17000, 16'd30000, 12'd2048));
      send_reading(make_item(32'd20302, 16'd24576, 12'd2048));
      send_reading(make_item(32'd20302, 16'd24575, 12'd4095));
      send_reading(make_item(32'd20400, 16'd49152, 12'd2048));
      send_reading(make_item(32'd20500, 16'd49153, 12'd2048));
      send_reading(make_item(32'hFFFF_FF00, 16'd0, 12'd0));
      // The freeze span here crosses the rollover of the time stamp.
      send_reading(make_item(32'h0000_1300, 16'd0, 12'd4095));
      send_reading(make_item(32'h0000_1400, 16'hFFFF, 12'd4095));
      send_reading(make_item(32'hFFFF_FFFF, 16'd0, 12'd0));
      send_reading(make_item(32'd0, 16'd30000, 12'd0));
      send_reading(make_item(32'd4000, 16'd0, 12'd0));
      sim_ms = 32'd4000;
   endtask

   task automatic test_reset_settings();
      run_random(250);
   endtask

   // All registers at zero, then all at their maximum; a 16-bit write of all ones
   // also checks that the position registers keep only their low 12 bits.
   task automatic test_extreme_settings();
      write_settings('0, '0, '0, '0, '0, '0, '0, '0);
      run_random(80);
      write_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                     16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      run_random(80);
   endtask

   // Short timeouts keep the member cycling through the poses; the upper bits of
   // the position writes are junk that the block must drop.
   task automatic test_short_timeouts();
      write_settings(16'hA000, 16'h5000, 16'd300, 16'd100,
                     16'hF064, 16'hA7D0, 16'h5F3C, 16'hC028);
      run_random(300);
   endtask

   task automatic test_random_settings();
      logic [15:0] loud_thr;
      for (int round = 0; round < 3; round++) begin
         loud_thr = 16'($urandom);
         write_settings(loud_thr, 16'($urandom_range(0, loud_thr)),
                        16'($urandom_range(0, 3000)), 16'($urandom_range(0, 800)),
                        16'($urandom), 16'($urandom), 16'($urandom),
                        16'($urandom_range(0, 400) | ($urandom_range(0, 15) << 12)));
         run_random(150);
      end
   endtask

   // -------------------------------------------------------------------------
   // Result checking
   // -------------------------------------------------------------------------

   task automatic flag_field(input string field, input int unsigned want,
                             input int unsigned got);
      fail_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
   endtask

   // Every edge the receiver decides whether to stall on the next one; a result
   // transfer is checked against the oldest expectation.
   always @(posedge clock) begin
      result_type want;
      rsp_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_results.size() == 0) begin
            fail_count++;
            $display("%0t: result with nothing expected, actual mode %0d target %0d",
                     $time, rsp_bus.mode, rsp_bus.target_position);
         end else begin
            want = pending_results.pop_front();
            results_checked++;
            if (rsp_bus.mode < 6)
               mode_seen[rsp_bus.mode]++;
            if (rsp_bus.mode !== want.mode)
               flag_field("mode", want.mode, rsp_bus.mode);
            if (rsp_bus.target_position !== want.target_position)
               flag_field("target_position", want.target_position, rsp_bus.target_position);
            if (rsp_bus.speed_is_fast !== want.speed_is_fast)
               flag_field("speed_is_fast", want.speed_is_fast, rsp_bus.speed_is_fast);
            if (rsp_bus.idle !== want.idle)
               flag_field("idle", want.idle, rsp_bus.idle);
         end
      end
   end

   // Watchdog: a hang anywhere ends the run as a failure.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // Sequence of the run
   // -------------------------------------------------------------------------

   initial begin
      reset            = 1'b1;
      csr_we           = 1'b0;
      csr_index        = '0;
      csr_wdata        = '0;
      req_bus.valid    = 1'b0;
      req_bus.now_ms   = '0;
      req_bus.loudness = '0;
      req_bus.position = '0;
      rsp_bus.ready    = 1'b0;
      fail_count       = 0;
      readings_sent    = 0;
      results_checked  = 0;
      settings_applied = 0;
      cycle_count      = 0;
      sim_ms           = '0;
      foreach (mode_seen[m])
         mode_seen[m] = 0;

      // Predictor copy of the reset state: reset settings, moving in, fast, toward
      // the in pose, both timers started at zero.
      cfg.loud_threshold     = RST_LOUD_THR;
      cfg.medium_threshold   = RST_MEDIUM_THR;
      cfg.freeze_timeout     = RST_FREEZE_TO;
      cfg.move_timeout       = RST_MOVE_TO;
      cfg.in_position        = RST_IN_POS;
      cfg.half_position      = RST_HALF_POS;
      cfg.out_position       = RST_OUT_POS;
      cfg.position_tolerance = RST_POS_TOL;
      st_mode     = MODE_MOVE_IN;
      st_target   = RST_IN_POS;
      st_fast     = 1'b1;
      st_idle     = 1'b0;
      quiet_since = '0;
      move_since  = '0;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Sender stalls often, receiver more often.
      send_idle_pct = 30;
      recv_idle_pct = 60;
      test_directed_walk();
      test_reset_settings();

      // The other way round.
      send_idle_pct = 60;
      recv_idle_pct = 30;
      test_extreme_settings();
      test_short_timeouts();

      // Full rate on both sides.
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_settings();

      wait_drained();
      repeat (4) @(posedge clock);

      $display("Checked %0d results from %0d readings under %0d register settings.",
               results_checked, readings_sent, settings_applied + 1);
      $display("Results per mode in/half/out/moving out/moving half/moving in: %0d %0d %0d %0d %0d %0d",
               mode_seen[0], mode_seen[1], mode_seen[2], mode_seen[3], mode_seen[4], mode_seen[5]);
      if (fail_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
